// ===== design/nec_tx_pkg.sv =====
// Shared types and constants for the NEC infrared frame transmitter.
// Used by every module of the block; no dependencies.
package nec_tx_pkg;

  // Defaults for the top level parameters
  localparam int BUFFER_BYTES_DEF = 16;
  localparam int TICK_US_DEF      = 560;

  // Field and state widths
  localparam int CMD_W       = 2;
  localparam int INDEX_W     = 4;
  localparam int BYTE_W      = 8;
  localparam int FRAME_W     = 5;
  localparam int REPEAT_W    = 8;
  localparam int ELAPSED_W   = 17;
  localparam int BIT_POS_W   = 3;

  // Phase lengths in microseconds
  localparam int LEADER_MARK_US = 8950;
  localparam int LEADER_GAP_US  = 4450;
  localparam int BIT_MARK_US    = 560;
  localparam int ONE_GAP_US     = 1680;
  localparam int ZERO_GAP_US    = 560;
  localparam int STOP_MARK_US   = 560;
  localparam int STOP_GAP_US    = 560;
  localparam int PAUSE_US       = 100240;
  localparam int LAST_BIT       = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_START = 2'd2,
    CMD_STOP  = 2'd3
  } cmd_e;

  // Configuration register index (paddr[2])
  typedef enum logic {
    REG_FRAME_BYTES  = 1'b0,
    REG_REPEAT_COUNT = 1'b1
  } reg_idx_e;

  // One result transaction
  typedef struct packed {
    logic carrier_on;
    logic status_led;
    logic done_res;
    logic busy_res;
  } result_t;

endpackage

// ===== design/nec_tx_buffer.sv =====
// Frame byte buffer: one write port, one registered read port.
// Write-first forwarding so a write shows on the next read at once.
// Depends on nec_tx_pkg.
module nec_tx_buffer #(
  parameter int BUFFER_BYTES = nec_tx_pkg::BUFFER_BYTES_DEF,
  parameter int POS_W        = $clog2(BUFFER_BYTES + 1)
) (
  input  logic                             clk_i,
  input  logic                             we_i,
  input  logic [nec_tx_pkg::INDEX_W-1:0]   waddr_i,
  input  logic [nec_tx_pkg::BYTE_W-1:0]    wdata_i,
  input  logic [POS_W-1:0]                 raddr_i,
  output logic [nec_tx_pkg::BYTE_W-1:0]    rdata_o
);

  localparam int AW = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;

  logic [nec_tx_pkg::BYTE_W-1:0] mem [BUFFER_BYTES];
  logic [nec_tx_pkg::BYTE_W-1:0] rdata_q;
  logic                          w_ok;
  logic                          r_ok;
  logic [AW-1:0]                 waddr;
  logic [AW-1:0]                 raddr;

  // Out-of-range writes are dropped
  assign w_ok  = we_i && (32'(waddr_i) < 32'(BUFFER_BYTES));
  assign r_ok  = 32'(raddr_i) < 32'(BUFFER_BYTES);
  assign waddr = AW'(waddr_i);
  assign raddr = AW'(raddr_i);

  always_ff @(posedge clk_i) begin
    if (w_ok) begin
      mem[waddr] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!r_ok) begin
      rdata_q <= '0;
    end else if (w_ok && (waddr == raddr)) begin
      rdata_q <= wdata_i;
    end else begin
      rdata_q <= mem[raddr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/nec_tx_fsm.sv =====
// Frame sequencer: phase timer, bit/byte counters, repeat counter.
// Updates on each accepted transaction; depends on nec_tx_pkg.
module nec_tx_fsm #(
  parameter int BUFFER_BYTES = nec_tx_pkg::BUFFER_BYTES_DEF,
  parameter int TICK_US      = nec_tx_pkg::TICK_US_DEF,
  parameter int POS_W        = $clog2(BUFFER_BYTES + 1)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              accept_i,
  input  nec_tx_pkg::cmd_e                  cmd_i,
  input  logic [nec_tx_pkg::FRAME_W-1:0]    frame_bytes_i,
  input  logic [nec_tx_pkg::REPEAT_W-1:0]   repeat_count_i,
  input  logic [nec_tx_pkg::BYTE_W-1:0]     rd_byte_i,
  output logic [POS_W-1:0]                  byte_pos_next_o,
  output nec_tx_pkg::result_t               result_o
);

  localparam int EW = nec_tx_pkg::ELAPSED_W;
  localparam int BW = nec_tx_pkg::BIT_POS_W;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_LEAD_MARK = 3'd1,
    PH_LEAD_GAP  = 3'd2,
    PH_DATA_MARK = 3'd3,
    PH_DATA_GAP  = 3'd4,
    PH_STOP_MARK = 3'd5,
    PH_STOP_GAP  = 3'd6,
    PH_PAUSE     = 3'd7
  } phase_e;

  phase_e                            phase_q, phase_d;
  logic [EW-1:0]                     elapsed_q, elapsed_d;
  logic                              gap_long_q, gap_long_d;
  logic [POS_W-1:0]                  byte_pos_q, byte_pos_d;
  logic [BW-1:0]                     bit_pos_q, bit_pos_d;
  logic [nec_tx_pkg::REPEAT_W-1:0]   repeats_q, repeats_d;
  logic                              carrier_q, carrier_d;
  logic                              led_q, led_d;
  logic                              done_d;

  logic [EW-1:0]                     elapsed_sum;
  logic [EW-1:0]                     gap_len;
  logic [POS_W-1:0]                  eff_size;
  logic [POS_W-1:0]                  byte_pos_inc;
  logic                              cur_bit;

  assign elapsed_sum  = elapsed_q + EW'(TICK_US);
  assign gap_len      = gap_long_q ? EW'(nec_tx_pkg::ONE_GAP_US)
                                   : EW'(nec_tx_pkg::ZERO_GAP_US);
  assign byte_pos_inc = byte_pos_q + POS_W'(1);
  assign cur_bit      = rd_byte_i[BW'(nec_tx_pkg::LAST_BIT) - bit_pos_q];

  // Frame length: zero sends one byte, oversize saturates to the buffer
  always_comb begin
    if (frame_bytes_i == '0) begin
      eff_size = POS_W'(1);
    end else if (32'(frame_bytes_i) > 32'(BUFFER_BYTES)) begin
      eff_size = POS_W'(BUFFER_BYTES);
    end else begin
      eff_size = POS_W'(frame_bytes_i);
    end
  end

  always_comb begin
    phase_d    = phase_q;
    elapsed_d  = elapsed_q;
    gap_long_d = gap_long_q;
    byte_pos_d = byte_pos_q;
    bit_pos_d  = bit_pos_q;
    repeats_d  = repeats_q;
    carrier_d  = carrier_q;
    led_d      = led_q;
    done_d     = 1'b0;
    if (accept_i) begin
      unique case (cmd_i)
        nec_tx_pkg::CMD_TICK: begin
          if (phase_q != PH_IDLE) begin
            elapsed_d = elapsed_sum;
          end
          unique case (phase_q)
            PH_IDLE: begin
            end
            PH_LEAD_MARK: begin
              if (elapsed_sum >= EW'(nec_tx_pkg::LEADER_MARK_US)) begin
                elapsed_d = '0;
                carrier_d = 1'b0;
                phase_d   = PH_LEAD_GAP;
              end
            end
            PH_LEAD_GAP: begin
              if (elapsed_sum >= EW'(nec_tx_pkg::LEADER_GAP_US)) begin
                elapsed_d = '0;
                carrier_d = 1'b1;
                phase_d   = PH_DATA_MARK;
              end
            end
            PH_DATA_MARK: begin
              if (elapsed_sum >= EW'(nec_tx_pkg::BIT_MARK_US)) begin
                elapsed_d  = '0;
                carrier_d  = 1'b0;
                phase_d    = PH_DATA_GAP;
                gap_long_d = cur_bit;
              end
            end
            PH_DATA_GAP: begin
              if (elapsed_sum >= gap_len) begin
                elapsed_d = '0;
                carrier_d = 1'b1;
                phase_d   = PH_DATA_MARK;
                if (bit_pos_q == BW'(nec_tx_pkg::LAST_BIT)) begin
                  bit_pos_d  = '0;
                  byte_pos_d = byte_pos_inc;
                  if (byte_pos_inc >= eff_size) begin
                    phase_d = PH_STOP_MARK;
                  end
                end else begin
                  bit_pos_d = bit_pos_q + BW'(1);
                end
              end
            end
            PH_STOP_MARK: begin
              if (elapsed_sum >= EW'(nec_tx_pkg::STOP_MARK_US)) begin
                elapsed_d = '0;
                carrier_d = 1'b0;
                phase_d   = PH_STOP_GAP;
              end
            end
            PH_STOP_GAP: begin
              if (elapsed_sum >= EW'(nec_tx_pkg::STOP_GAP_US)) begin
                elapsed_d = '0;
                led_d     = 1'b1;
                phase_d   = PH_PAUSE;
              end
            end
            PH_PAUSE: begin
              if (elapsed_sum >= EW'(nec_tx_pkg::PAUSE_US)) begin
                elapsed_d = '0;
                led_d     = 1'b0;
                repeats_d = repeats_q - nec_tx_pkg::REPEAT_W'(1);
                if (repeats_q == 8'd1) begin
                  phase_d = PH_IDLE;
                  done_d  = 1'b1;
                end else begin
                  byte_pos_d = '0;
                  bit_pos_d  = '0;
                  carrier_d  = 1'b1;
                  phase_d    = PH_LEAD_MARK;
                end
              end
            end
            default: begin
            end
          endcase
        end
        nec_tx_pkg::CMD_WRITE: begin
          // buffer write handled by the buffer module
        end
        nec_tx_pkg::CMD_START: begin
          repeats_d  = repeat_count_i;
          led_d      = 1'b0;
          gap_long_d = 1'b0;
          byte_pos_d = '0;
          bit_pos_d  = '0;
          elapsed_d  = '0;
          carrier_d  = 1'b1;
          phase_d    = PH_LEAD_MARK;
        end
        nec_tx_pkg::CMD_STOP: begin
          phase_d   = PH_IDLE;
          carrier_d = 1'b0;
          led_d     = 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      elapsed_q  <= '0;
      gap_long_q <= 1'b0;
      byte_pos_q <= '0;
      bit_pos_q  <= '0;
      repeats_q  <= '0;
      carrier_q  <= 1'b0;
      led_q      <= 1'b0;
    end else begin
      phase_q    <= phase_d;
      elapsed_q  <= elapsed_d;
      gap_long_q <= gap_long_d;
      byte_pos_q <= byte_pos_d;
      bit_pos_q  <= bit_pos_d;
      repeats_q  <= repeats_d;
      carrier_q  <= carrier_d;
      led_q      <= led_d;
    end
  end

  // Buffer read address tracks the next byte position
  assign byte_pos_next_o     = byte_pos_d;
  assign result_o.carrier_on = carrier_d;
  assign result_o.status_led = led_d;
  assign result_o.done_res   = done_d;
  assign result_o.busy_res   = (phase_d != PH_IDLE);

endmodule

// ===== design/nec_tx_out_fifo.sv =====
// Two-entry result queue between the sequencer and the output channel.
// Depends on nec_tx_pkg.
module nec_tx_out_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  nec_tx_pkg::result_t  push_data_i,
  input  logic                 pop_i,
  output logic                 full_o,
  output logic                 valid_o,
  output nec_tx_pkg::result_t  data_o
);

  nec_tx_pkg::result_t entry_q [2];
  logic                wr_ptr_q;
  logic                rd_ptr_q;
  logic [1:0]          count_q;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  assign full_o  = count_q[1];
  assign valid_o = (count_q != '0);
  assign data_o  = entry_q[rd_ptr_q];

endmodule

// ===== design/nec_ir_frame_transmitter_core.sv =====
// NEC infrared frame transmitter, top level; uses nec_tx_pkg, buffer, fsm and result queue.
// Each accepted input pushes its result into the result queue, which drives the output channel.
// Throughput: one transaction per cycle; a two-entry result queue holds results
// while the output stalls, and input stalls only when that queue is full.
// Reset (rst_ni, async, active low): idle, counters and out_valid_o cleared,
// frame_bytes = 4, repeat_count = 1; the frame buffer and result queue entries hold no reset value.
module nec_ir_frame_transmitter_core #(
  parameter int BUFFER_BYTES = nec_tx_pkg::BUFFER_BYTES_DEF,
  parameter int TICK_US      = nec_tx_pkg::TICK_US_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // APB-style configuration port
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // input channel
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [nec_tx_pkg::CMD_W-1:0]     cmd_i,
  input  logic [nec_tx_pkg::INDEX_W-1:0]   byte_index_i,
  input  logic [nec_tx_pkg::BYTE_W-1:0]    byte_value_i,
  // output channel
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic                             carrier_on_o,
  output logic                             status_led_o,
  output logic                             done_res_o,
  output logic                             busy_res_o
);

  localparam int POS_W = $clog2(BUFFER_BYTES + 1);

  logic [nec_tx_pkg::FRAME_W-1:0]  frame_bytes_q;
  logic [nec_tx_pkg::REPEAT_W-1:0] repeat_count_q;
  logic                            cfg_wr;
  nec_tx_pkg::reg_idx_e            cfg_idx;

  logic                            accept;
  logic                            pop;
  logic                            fifo_full;
  nec_tx_pkg::cmd_e                cmd;
  logic [POS_W-1:0]                rd_addr;
  logic [nec_tx_pkg::BYTE_W-1:0]   rd_byte;
  nec_tx_pkg::result_t             result_next;
  nec_tx_pkg::result_t             result_out;

  // ---------------------------------------------------------------------
  // Configuration registers: written in the APB access phase, no wait states
  // ---------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = nec_tx_pkg::reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_bytes_q  <= nec_tx_pkg::FRAME_W'(4);
      repeat_count_q <= nec_tx_pkg::REPEAT_W'(1);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        nec_tx_pkg::REG_FRAME_BYTES:  frame_bytes_q  <= pwdata[nec_tx_pkg::FRAME_W-1:0];
        nec_tx_pkg::REG_REPEAT_COUNT: repeat_count_q <= pwdata[nec_tx_pkg::REPEAT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      nec_tx_pkg::REG_FRAME_BYTES:  prdata = 32'(frame_bytes_q);
      nec_tx_pkg::REG_REPEAT_COUNT: prdata = 32'(repeat_count_q);
      default:                      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake: input stalls only when both result slots are occupied
  // ---------------------------------------------------------------------
  assign in_stall_o = fifo_full;
  assign accept     = in_valid_i && !fifo_full;
  assign pop        = out_valid_o && !out_stall_i;
  assign cmd        = nec_tx_pkg::cmd_e'(cmd_i);

  // Byte buffer; read port follows the sequencer's next byte position so
  // the byte is ready by the time its bits go out
  nec_tx_buffer #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .POS_W        (POS_W)
  ) u_buffer (
    .clk_i   (clk_i),
    .we_i    (accept && (cmd == nec_tx_pkg::CMD_WRITE)),
    .waddr_i (byte_index_i),
    .wdata_i (byte_value_i),
    .raddr_i (rd_addr),
    .rdata_o (rd_byte)
  );

  // Phase sequencer; result fields reflect state after the transaction
  nec_tx_fsm #(
    .BUFFER_BYTES (BUFFER_BYTES),
    .TICK_US      (TICK_US),
    .POS_W        (POS_W)
  ) u_fsm (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .accept_i        (accept),
    .cmd_i           (cmd),
    .frame_bytes_i   (frame_bytes_q),
    .repeat_count_i  (repeat_count_q),
    .rd_byte_i       (rd_byte),
    .byte_pos_next_o (rd_addr),
    .result_o        (result_next)
  );

  // Result queue, one entry per accepted transaction
  nec_tx_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (accept),
    .push_data_i (result_next),
    .pop_i       (pop),
    .full_o      (fifo_full),
    .valid_o     (out_valid_o),
    .data_o      (result_out)
  );

  assign carrier_on_o = result_out.carrier_on;
  assign status_led_o = result_out.status_led;
  assign done_res_o   = result_out.done_res;
  assign busy_res_o   = result_out.busy_res;

`ifndef ASSERT_OFF
  // done marks the end of the last frame, so the block is idle with it
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && done_res_o) |-> (!busy_res_o && !carrier_on_o && !status_led_o))
    else $error("done reported while still busy");

  // LED is only on in the pause, where the carrier is off
  a_led_pause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_led_o) |-> (busy_res_o && !carrier_on_o))
    else $error("status LED outside the inter-frame pause");

  // a start always leaves the block busy with the carrier on
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && (cmd == nec_tx_pkg::CMD_START)) |->
      (result_next.busy_res && result_next.carrier_on && !result_next.status_led))
    else $error("start did not begin a frame");
`endif

endmodule
